/* hdl/kdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types and constants for the keyed device table.
// ----------------------------------------------------------------------------
package kdt_pkg;

  localparam int MAX_ENTRIES   = 32;
  localparam int PAYLOAD_WIDTH = 64;
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W   = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] CODE_NEW      = 3'd0;
  localparam logic [2:0] CODE_EXISTING = 3'd1;
  localparam logic [2:0] CODE_FULL     = 3'd2;
  localparam logic [2:0] CODE_OK       = 3'd3;
  localparam logic [2:0] CODE_MISSING  = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  bus;
    logic [4:0]  slot;
    logic [2:0]  func;
    logic [31:0] status;
    logic [63:0] info;
    logic [4:0]  index;
  } kdt_in_t;

  typedef struct packed {
    logic [2:0]  code;
    logic        found;
    logic [7:0]  out_bus;
    logic [4:0]  out_slot;
    logic [2:0]  out_func;
    logic [31:0] out_status;
    logic [63:0] out_info;
    logic [5:0]  entry_count;
  } kdt_out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } kdt_cmd_t;

endpackage

/* hdl/kdt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/kdt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_ctrl
// Sequencer: accepts a command, runs the search cycle, then issues the result.
// ----------------------------------------------------------------------------
module kdt_ctrl
  import kdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output kdt_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESP   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy     = (state == ST_SEARCH);
  assign done     = (state == ST_RESP);
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == ST_SEARCH);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = start ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_search_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done) else $error("search cycle not followed by a result");
  a_done_needs_search: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec)) else $error("result without a preceding search");

endmodule

/* hdl/kdt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_datapath
// Key registers with parallel compare, record RAMs, fill count and result.
// ----------------------------------------------------------------------------
module kdt_datapath
  import kdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  kdt_cmd_t cmd,
  input  kdt_in_t  item,
  output kdt_out_t result
);

  kdt_in_t            q;
  logic [KEY_W-1:0]   keys [MAX_ENTRIES];
  logic [COUNT_W-1:0] fill_count;
  logic [KEY_W-1:0]   key;
  logic [MAX_ENTRIES-1:0] match;
  logic [IDX_W-1:0]   hit_idx;
  logic               hit;
  logic               full;
  logic [IDX_W-1:0]   tail_idx;
  logic [IDX_W-1:0]   pos_idx;
  logic               pos_ok;

  logic [2:0]         code_next;
  logic               found_next;
  logic               status_we;
  logic               payload_we;
  logic               key_we;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;

  logic [2:0]         code_r;
  logic               found_r;
  logic [KEY_W-1:0]   rec_key;
  logic [31:0]        status_rdata;
  logic [PAYLOAD_WIDTH-1:0] payload_rdata;

  assign key      = {q.bus, q.slot, q.func};
  assign full     = (fill_count == COUNT_W'(MAX_ENTRIES));
  assign tail_idx = fill_count[IDX_W-1:0];
  assign pos_idx  = IDX_W'(q.index);
  assign pos_ok   = (32'(q.index) < 32'(fill_count)) && (32'(q.index) < MAX_ENTRIES);

  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      match[k] = (keys[k] == key) && (32'(k) < 32'(fill_count));
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (match[k]) hit_idx = hit_idx | IDX_W'(k);
    end
  end

  assign hit = |match;

  always_comb begin
    code_next  = CODE_MISSING;
    found_next = 1'b0;
    status_we  = 1'b0;
    payload_we = 1'b0;
    key_we     = 1'b0;
    waddr      = hit_idx;
    raddr      = hit_idx;
    unique case (q.op)
      OP_ADD: begin
        if (hit) begin
          code_next  = CODE_EXISTING;
          status_we  = cmd.exec;
          payload_we = cmd.exec;
        end else if (full) begin
          code_next = CODE_FULL;
        end else begin
          code_next  = CODE_NEW;
          waddr      = tail_idx;
          status_we  = cmd.exec;
          payload_we = cmd.exec;
          key_we     = cmd.exec;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          code_next  = CODE_OK;
          found_next = 1'b1;
        end
      end
      OP_SET: begin
        if (hit) begin
          code_next = CODE_OK;
          status_we = cmd.exec;
        end
      end
      OP_READ: begin
        raddr = pos_idx;
        if (pos_ok) begin
          code_next  = CODE_OK;
          found_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q <= item;
    end
    if (key_we) begin
      keys[tail_idx] <= key;
    end
    if (cmd.exec) begin
      code_r  <= code_next;
      rec_key <= (q.op == OP_LOOKUP) ? key : keys[pos_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      found_r    <= 1'b0;
    end else begin
      if (key_we) begin
        fill_count <= fill_count + COUNT_W'(1);
      end
      if (cmd.exec) begin
        found_r <= found_next;
      end
    end
  end

  kdt_ram #(
    .WIDTH(32),
    .DEPTH(MAX_ENTRIES)
  ) u_status_ram (
    .clk  (clk),
    .we   (status_we),
    .waddr(waddr),
    .wdata(q.status),
    .raddr(raddr),
    .rdata(status_rdata)
  );

  kdt_ram #(
    .WIDTH(PAYLOAD_WIDTH),
    .DEPTH(MAX_ENTRIES)
  ) u_payload_ram (
    .clk  (clk),
    .we   (payload_we),
    .waddr(waddr),
    .wdata(q.info[PAYLOAD_WIDTH-1:0]),
    .raddr(raddr),
    .rdata(payload_rdata)
  );

  always_comb begin
    result.code        = code_r;
    result.found       = found_r;
    result.out_bus     = found_r ? rec_key[15:8] : '0;
    result.out_slot    = found_r ? rec_key[7:3] : '0;
    result.out_func    = found_r ? rec_key[2:0] : '0;
    result.out_status  = found_r ? status_rdata : '0;
    result.out_info    = found_r ? 64'(payload_rdata) : '0;
    result.entry_count = 6'(fill_count);
  end

  a_keys_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match)) else $error("key held in more than one entry");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= MAX_ENTRIES) else $error("entry count beyond capacity");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !key_we |=> $stable(fill_count)) else $error("entry count changed without append");

endmodule

/* hdl/keyed_device_table.sv */
// The sequencer steps from idle to search to result; done is high in the result state, and the
// result transfers at the edge that ends it.
// Commands overlap: the key search and RAM write-back take the search state
// and the registered RAM read takes the result state, during which start is accepted again.
// Reset clears the entry count and the sequencer; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_device_table
// Table of device records keyed by bus, slot and function with append-insert.
// ----------------------------------------------------------------------------
module keyed_device_table
  import kdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  kdt_in_t  item,
  output logic     done,
  output kdt_out_t result
);

  kdt_cmd_t cmd;

  kdt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  kdt_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .item  (item),
    .result(result)
  );

endmodule

/* tb/keyed_device_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_device_table_test
// Self-checking bench for the keyed device table. Commands go in through the
// start/busy handshake, and each one is run against a behavioral copy of the
// table when it is accepted. Every done strobe is compared field by field
// with the oldest pending prediction. Directed cases on an empty and lightly
// filled table come first. Random traffic over a small key pool follows; it
// fills the table, then keeps hitting refresh, full, miss and read paths
// while the sender's idle rate changes.
// ----------------------------------------------------------------------------
module keyed_device_table_test;
  import kdt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int KEY_POOL_SIZE = 40;
  localparam int SETTLE_CYCLES = 4;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  kdt_in_t  item = '0;
  logic     done;
  kdt_out_t result;

  keyed_device_table uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Behavioral copy of the table.
  logic [KEY_W-1:0]         held_key [MAX_ENTRIES];
  logic [31:0]              held_status [MAX_ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] held_info [MAX_ENTRIES];
  int                       held_count = 0;

  kdt_out_t    pending_results[$];
  logic [15:0] key_pool [KEY_POOL_SIZE];
  int          errors = 0;
  int          checked = 0;
  int          code_tally [5] = '{default: 0};
  int          cycle_count = 0;

  function automatic kdt_out_t record_at(int pos);
    kdt_out_t r;
    r = '0;
    r.found = 1'b1;
    {r.out_bus, r.out_slot, r.out_func} = held_key[pos];
    r.out_status = held_status[pos];
    r.out_info = 64'(held_info[pos]);
    return r;
  endfunction

  function automatic kdt_out_t apply_command(kdt_in_t c);
    kdt_out_t         r;
    logic [KEY_W-1:0] key;
    int               hit;
    r = '0;
    key = {c.bus, c.slot, c.func};
    hit = -1;
    for (int k = 0; k < held_count; k++) begin
      if (hit < 0 && held_key[k] == key) begin
        hit = k;
      end
    end
    r.code = CODE_MISSING;
    case (c.op)
      OP_ADD: begin
        if (hit >= 0) begin
          held_status[hit] = c.status;
          held_info[hit] = c.info[PAYLOAD_WIDTH-1:0];
          r.code = CODE_EXISTING;
        end else if (held_count >= MAX_ENTRIES) begin
          r.code = CODE_FULL;
        end else begin
          held_key[held_count] = key;
          held_status[held_count] = c.status;
          held_info[held_count] = c.info[PAYLOAD_WIDTH-1:0];
          held_count++;
          r.code = CODE_NEW;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          r = record_at(hit);
          r.code = CODE_OK;
        end
      end
      OP_SET: begin
        if (hit >= 0) begin
          held_status[hit] = c.status;
          r.code = CODE_OK;
        end
      end
      default: begin
        if (int'(c.index) < held_count) begin
          r = record_at(int'(c.index));
          r.code = CODE_OK;
        end
      end
    endcase
    r.entry_count = 6'(held_count);
    return r;
  endfunction

  function automatic kdt_in_t make_command(logic [1:0] op, logic [7:0] bus, logic [4:0] slot,
                                           logic [2:0] func, logic [31:0] status,
                                           logic [63:0] info, logic [4:0] index);
    kdt_in_t c;
    c.op = op;
    c.bus = bus;
    c.slot = slot;
    c.func = func;
    c.status = status;
    c.info = info;
    c.index = index;
    return c;
  endfunction

  function automatic kdt_in_t random_command();
    kdt_in_t     c;
    int          pick;
    logic [15:0] key;
    pick = $urandom_range(99);
    if (pick < 35) begin
      c.op = OP_ADD;
    end else if (pick < 60) begin
      c.op = OP_LOOKUP;
    end else if (pick < 80) begin
      c.op = OP_SET;
    end else begin
      c.op = OP_READ;
    end
    if ($urandom_range(99) < 85) begin
      key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    end else begin
      key = 16'($urandom);
    end
    {c.bus, c.slot, c.func} = key;
    c.status = $urandom;
    c.info = {$urandom, $urandom};
    c.index = 5'($urandom);
    return c;
  endfunction

  // The caller is at a rising edge; start stays high after the transfer so
  // that a following command can go out without a gap.
  task automatic send_command(kdt_in_t c);
    start <= 1'b1;
    item <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(c));
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_empty_table();
    send_command(make_command(OP_LOOKUP, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_SET, 8'h00, 5'h00, 3'h0, 32'hffffffff, 64'h0, 5'h00));
    send_command(make_command(OP_READ, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_READ, 8'hff, 5'h1f, 3'h7, 32'h0, 64'h0, 5'h1f));
  endtask

  task automatic test_add_and_refresh();
    send_command(make_command(OP_ADD, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_ADD, 8'hff, 5'h1f, 3'h7, 32'hffffffff,
                              64'hffffffff_ffffffff, 5'h1f));
    send_command(make_command(OP_ADD, 8'h00, 5'h00, 3'h0, 32'ha5a5a5a5,
                              64'h5a5a5a5a_a5a5a5a5, 5'h00));
    send_command(make_command(OP_ADD, 8'hff, 5'h00, 3'h0, 32'h12345678,
                              64'h01234567_89abcdef, 5'h0a));
    send_command(make_command(OP_ADD, 8'hff, 5'h1f, 3'h7, 32'h00000001,
                              64'h80000000_00000000, 5'h15));
  endtask

  task automatic test_lookup_set_read();
    send_command(make_command(OP_LOOKUP, 8'hff, 5'h1f, 3'h7, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_LOOKUP, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h1f));
    send_command(make_command(OP_LOOKUP, 8'hff, 5'h1f, 3'h6, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_LOOKUP, 8'h7f, 5'h1f, 3'h7, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_SET, 8'hff, 5'h1f, 3'h7, 32'h00000000,
                              64'hffffffff_ffffffff, 5'h00));
    send_command(make_command(OP_SET, 8'h01, 5'h10, 3'h4, 32'hdeadbeef, 64'h0, 5'h00));
    send_command(make_command(OP_LOOKUP, 8'hff, 5'h1f, 3'h7, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_READ, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h00));
    send_command(make_command(OP_READ, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h01));
    send_command(make_command(OP_READ, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h02));
    send_command(make_command(OP_READ, 8'h00, 5'h00, 3'h0, 32'h0, 64'h0, 5'h03));
    send_command(make_command(OP_READ, 8'hff, 5'h1f, 3'h7, 32'hffffffff,
                              64'hffffffff_ffffffff, 5'h1f));
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    for (int n = 0; n < count; n++) begin
      send_command(random_command());
      idle_gap(idle_pct);
    end
    drain_results();
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    kdt_out_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %p", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("code", 64'(want.code), 64'(result.code));
        check_field("found", 64'(want.found), 64'(result.found));
        check_field("out_bus", 64'(want.out_bus), 64'(result.out_bus));
        check_field("out_slot", 64'(want.out_slot), 64'(result.out_slot));
        check_field("out_func", 64'(want.out_func), 64'(result.out_func));
        check_field("out_status", 64'(want.out_status), 64'(result.out_status));
        check_field("out_info", want.out_info, result.out_info);
        check_field("entry_count", 64'(want.entry_count), 64'(result.entry_count));
        code_tally[want.code]++;
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hffff;
    for (int k = 2; k < KEY_POOL_SIZE; k++) begin
      key_pool[k] = 16'($urandom);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_add_and_refresh();
    test_lookup_set_read();
    drain_results();
    test_random_traffic(250, 36);
    test_random_traffic(250, 78);
    test_random_traffic(250, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected %p, actual none", $time,
               pending_results.size(), pending_results[0]);
    end
    $display("Checked %0d transfers with the table ending at %0d of %0d entries.",
             checked, held_count, MAX_ENTRIES);
    $display("Codes seen: %0d new, %0d refreshed, %0d full, %0d ok, %0d not found.",
             code_tally[CODE_NEW], code_tally[CODE_EXISTING], code_tally[CODE_FULL],
             code_tally[CODE_OK], code_tally[CODE_MISSING]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* keyed_device_table.f */
hdl/kdt_pkg.sv
hdl/kdt_ram.sv
hdl/kdt_ctrl.sv
hdl/kdt_datapath.sv
hdl/keyed_device_table.sv
tb/keyed_device_table_test.sv
